@@ design/arwc_pkg.sv @@
// shared types and constants for the add-rotate word cipher
// used by arwc_sched, arwc_round, add_rotate_word_cipher and arwc_checker
`timescale 1ns / 1ps

package arwc_pkg;

    localparam int WORD_W         = 32;
    localparam int NUM_ROUNDS_DEF = 64;
    localparam int ROT_AMT        = 3;

    localparam logic [WORD_W-1:0] SCHED_ADD = 32'h06DC597F;
    localparam logic [WORD_W-1:0] SCHED_MUL = 32'h5851F42D;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // control that travels alongside each word through the round pipeline
    typedef struct packed {
        logic valid;
        logic op;
        logic last;
    } t_stage_ctl;

endpackage

@@ design/add_rotate_word_cipher.sv @@
// top level of the add-rotate word cipher: schedule unit and round pipeline
// depends on arwc_pkg, arwc_sched, arwc_round
`timescale 1ns / 1ps

// Streams 32-bit words through NUM_ROUNDS registered rounds, one round per
// stage, so a word accepted on the slave side passes through every round
// register to the master side; a new word can be taken every cycle unless
// the pipeline is held or the schedule is being rebuilt. tuser picks encrypt
// (0) or decrypt (1) per word and tlast is carried through untouched. The
// whole pipeline holds while the output word waits for tready. After reset
// and after every key write a single shared multiplier recomputes the round
// words, an add and a multiply step per word after the key itself, while
// s_axis tready is low. Write the key only when no words are in flight.
module add_rotate_word_cipher #(
    parameter int NUM_ROUNDS = arwc_pkg::NUM_ROUNDS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [arwc_pkg::WORD_W-1:0] i_cfg_wr_data,   // cipher_key
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [arwc_pkg::WORD_W-1:0] i_s_axis_tdata,  // [31:0] data_word
    input  logic                        i_s_axis_tuser,  // [0] opcode
    input  logic                        i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [arwc_pkg::WORD_W-1:0] o_m_axis_tdata,  // [31:0] result_word
    output logic                        o_m_axis_tlast
);
    import arwc_pkg::*;

    logic                                  w_busy;
    logic                                  w_ce;
    logic [NUM_ROUNDS-1:0][WORD_W-1:0]     w_round_words;
    t_stage_ctl                            w_ctl  [NUM_ROUNDS+1];
    logic [WORD_W-1:0]                     w_data [NUM_ROUNDS+1];

    arwc_sched #(
        .NUM_ROUNDS (NUM_ROUNDS)
    ) u_sched (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_busy        (w_busy),
        .o_round_words (w_round_words)
    );

    // pipeline advances unless the output word is stuck
    assign w_ce            = !w_ctl[NUM_ROUNDS].valid || i_m_axis_tready;
    assign o_s_axis_tready = w_ce && !w_busy;

    assign w_ctl[0].valid = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ctl[0].op    = i_s_axis_tuser;
    assign w_ctl[0].last  = i_s_axis_tlast;
    assign w_data[0]      = i_s_axis_tdata;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        arwc_round u_round (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ce       (w_ce),
            .i_ctl      (w_ctl[g]),
            .i_data     (w_data[g]),
            .i_enc_word (w_round_words[g]),
            .i_dec_word (w_round_words[NUM_ROUNDS-1-g]),
            .o_ctl      (w_ctl[g+1]),
            .o_data     (w_data[g+1])
        );
    end

    assign o_m_axis_tvalid = w_ctl[NUM_ROUNDS].valid;
    assign o_m_axis_tdata  = w_data[NUM_ROUNDS];
    assign o_m_axis_tlast  = w_ctl[NUM_ROUNDS].last;

endmodule

@@ design/arwc_sched.sv @@
// round word schedule: key register and sequential expansion into round words
// depends on arwc_pkg
`timescale 1ns / 1ps

module arwc_sched #(
    parameter int NUM_ROUNDS = arwc_pkg::NUM_ROUNDS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_cfg_wr_en,
    input  logic [arwc_pkg::WORD_W-1:0]                 i_cfg_wr_data,
    output logic                                        o_busy,
    output logic [NUM_ROUNDS-1:0][arwc_pkg::WORD_W-1:0] o_round_words
);
    import arwc_pkg::*;

    localparam int IDX_W = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_ADD  = 4'b0010,
        S_MUL  = 4'b0100,
        S_IDLE = 4'b1000
    } t_sched_state;

    t_sched_state      r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WORD_W-1:0] r_key;
    logic [WORD_W-1:0] r_w, n_w;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic [WORD_W-1:0] r_rw [NUM_ROUNDS];

    logic              w_wr_en;
    logic [IDX_W-1:0]  w_wr_idx;
    logic [WORD_W-1:0] w_wr_data;
    logic [IDX_W-1:0]  w_next_idx;
    logic [WORD_W-1:0] w_prod;

    assign w_next_idx = r_idx + 1'b1;
    assign w_prod     = r_sum * SCHED_MUL;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_w       = r_w;
        n_sum     = r_sum;
        w_wr_en   = 1'b0;
        w_wr_idx  = '0;
        w_wr_data = r_w;
        case (r_state)
            S_LOAD: begin
                n_w       = r_key;
                n_idx     = '0;
                w_wr_en   = 1'b1;
                w_wr_data = r_key;
                if (NUM_ROUNDS > 1) begin
                    n_state = S_ADD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                n_sum   = r_w + SCHED_ADD;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_w       = w_prod;
                n_idx     = w_next_idx;
                w_wr_en   = 1'b1;
                w_wr_idx  = w_next_idx;
                w_wr_data = w_prod;
                if (w_next_idx == IDX_W'(NUM_ROUNDS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ADD;
                end
            end
            S_IDLE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_key   <= '0;
        end else if (i_cfg_wr_en) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_key   <= i_cfg_wr_data;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_w   <= n_w;
        r_sum <= n_sum;
        if (w_wr_en) begin
            r_rw[w_wr_idx] <= w_wr_data;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_out
        assign o_round_words[g] = r_rw[g];
    end

endmodule

@@ design/arwc_round.sv @@
// one registered round of the cipher pipeline, encrypt or decrypt per word
// depends on arwc_pkg
`timescale 1ns / 1ps

module arwc_round (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_ce,
    input  arwc_pkg::t_stage_ctl          i_ctl,
    input  logic [arwc_pkg::WORD_W-1:0]   i_data,
    input  logic [arwc_pkg::WORD_W-1:0]   i_enc_word,
    input  logic [arwc_pkg::WORD_W-1:0]   i_dec_word,
    output arwc_pkg::t_stage_ctl          o_ctl,
    output logic [arwc_pkg::WORD_W-1:0]   o_data
);
    import arwc_pkg::*;

    t_stage_ctl        r_ctl;
    logic [WORD_W-1:0] r_data, n_data;
    logic [WORD_W-1:0] w_sum;
    logic [WORD_W-1:0] w_enc;
    logic [WORD_W-1:0] w_rotr;
    logic [WORD_W-1:0] w_dec;

    // encrypt: add then rotate left; decrypt: rotate right then subtract
    assign w_sum  = i_data + i_enc_word;
    assign w_enc  = {w_sum[WORD_W-ROT_AMT-1:0], w_sum[WORD_W-1:WORD_W-ROT_AMT]};
    assign w_rotr = {i_data[ROT_AMT-1:0], i_data[WORD_W-1:ROT_AMT]};
    assign w_dec  = w_rotr - i_dec_word;
    assign n_data = (i_ctl.op == OP_DECRYPT) ? w_dec : w_enc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_ce) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_data <= n_data;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_data = r_data;

endmodule

@@ design/arwc_checker.sv @@
// port-level checks for add_rotate_word_cipher, attached by bind
// depends on arwc_pkg and the top level's ports
`timescale 1ns / 1ps

module arwc_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_wr_en,
    input logic                        o_s_axis_tready,
    input logic                        o_m_axis_tvalid,
    input logic                        i_m_axis_tready,
    input logic [arwc_pkg::WORD_W-1:0] o_m_axis_tdata,
    input logic                        o_m_axis_tlast
);

    // no output transaction right after reset
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // schedule expansion blocks input right after reset
    a_reset_blocks_in: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_s_axis_tready)
        else $error("input ready while schedule is rebuilt after reset");

    // key write restarts the expansion and blocks input
    a_key_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr_en |=> !o_s_axis_tready)
        else $error("input ready right after key write");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

endmodule

bind add_rotate_word_cipher arwc_checker u_arwc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_wr_en     (i_cfg_wr_en),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

@@ sim/add_rotate_word_cipher_tb.sv @@
// self-checking testbench for add_rotate_word_cipher: directed and random words
// through both stream ports, checked against a key-schedule predictor; needs arwc_pkg
`timescale 1ns / 1ps

module add_rotate_word_cipher_tb;
    import arwc_pkg::*;

    localparam int ROUNDS     = NUM_ROUNDS_DEF;
    localparam int IDLE_LIMIT = 3000;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic              last;
    } t_cipher_out;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_wr_en;
    logic [WORD_W-1:0] i_cfg_wr_data;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [WORD_W-1:0] i_s_axis_tdata;   // [31:0] data_word
    logic              i_s_axis_tuser;   // [0] opcode
    logic              i_s_axis_tlast;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [WORD_W-1:0] o_m_axis_tdata;   // [31:0] result_word
    logic              o_m_axis_tlast;

    logic [WORD_W-1:0] round_key [ROUNDS];
    t_cipher_out       expected_out [$];
    int                error_count;
    int                idle_cycles;
    int                rx_hold;
    bit                gapless;

    add_rotate_word_cipher DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic void expand_key(input logic [WORD_W-1:0] key);
        logic [WORD_W-1:0] w;
        w = key;
        round_key[0] = w;
        for (int i = 1; i < ROUNDS; i++) begin
            w = (w + SCHED_ADD) * SCHED_MUL;
            round_key[i] = w;
        end
    endfunction

    function automatic logic [WORD_W-1:0] encipher(input logic [WORD_W-1:0] x);
        for (int j = 0; j < ROUNDS; j++) begin
            x = x + round_key[j];
            x = (x << ROT_AMT) | (x >> (WORD_W - ROT_AMT));
        end
        return x;
    endfunction

    function automatic logic [WORD_W-1:0] decipher(input logic [WORD_W-1:0] x);
        for (int j = ROUNDS - 1; j >= 0; j--) begin
            x = (x >> ROT_AMT) | (x << (WORD_W - ROT_AMT));
            x = x - round_key[j];
        end
        return x;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        if (gapless)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // ---------------- sender side ----------------

    task automatic send_word(input logic op, input logic [WORD_W-1:0] data, input logic last);
        int          gap;
        t_cipher_out exp_item;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tuser  <= op;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!o_s_axis_tready);
        exp_item.word = (op == OP_ENCRYPT) ? encipher(data) : decipher(data);
        exp_item.last = last;
        expected_out.push_back(exp_item);
    endtask

    // drop tvalid and hold off until every pending transaction has come out
    task automatic wait_drain();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (expected_out.size() != 0);
    endtask

    task automatic write_cipher_key(input logic [WORD_W-1:0] key);
        wait_drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= key;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        expand_key(key);
    endtask

    // a message of random words; in round-trip form each word is also sent back
    // as ciphertext so decryption sees well-formed input
    task automatic send_message(input int len, input bit round_trip);
        logic [WORD_W-1:0] plain [$];
        logic              op;
        for (int i = 0; i < len; i++) begin
            plain.push_back($urandom());
            op = round_trip ? OP_ENCRYPT : logic'($urandom_range(0, 1));
            send_word(op, plain[i], (i == len - 1) && !round_trip);
        end
        if (round_trip)
            for (int i = 0; i < len; i++)
                send_word(OP_DECRYPT, encipher(plain[i]), i == len - 1);
    endtask

    task automatic random_words(input int n_items);
        int sent;
        int len;
        bit rt;
        bit stray;
        sent = 0;
        while (sent < n_items) begin
            len   = $urandom_range(1, 8);
            stray = ($urandom_range(0, 99) < 10);
            rt    = !stray && ($urandom_range(0, 99) < 40);
            if (stray)
                // stray words with random flags
                for (int i = 0; i < len; i++)
                    send_word(logic'($urandom_range(0, 1)), $urandom(),
                              logic'($urandom_range(0, 1)));
            else
                send_message(len, rt);
            sent += rt ? 2 * len : len;
            if (sent >= n_items / 2 && sent - (rt ? 2 * len : len) < n_items / 2)
                wait_drain();
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_schedule();
        send_word(OP_ENCRYPT, 32'h0000_0000, 1'b0);
        send_word(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_DECRYPT, 32'h0000_0000, 1'b0);
        send_word(OP_DECRYPT, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_ENCRYPT, 32'h8000_0000, 1'b0);
        send_word(OP_DECRYPT, 32'h0000_0001, 1'b1);
    endtask

    task automatic test_key_extremes();
        write_cipher_key(32'hFFFF_FFFF);
        send_word(OP_ENCRYPT, 32'h0000_0000, 1'b0);
        send_word(OP_DECRYPT, 32'hFFFF_FFFF, 1'b1);
        send_word(OP_ENCRYPT, 32'h5555_5555, 1'b0);
        send_word(OP_DECRYPT, 32'hAAAA_AAAA, 1'b1);
        // back to zero checks that the schedule is rebuilt, not kept
        write_cipher_key(32'h0000_0000);
        send_word(OP_ENCRYPT, 32'hFFFF_FFFF, 1'b1);
        write_cipher_key(32'h8000_0001);
        send_word(OP_DECRYPT, 32'h7FFF_FFFE, 1'b1);
    endtask

    task automatic test_round_trip();
        write_cipher_key($urandom());
        send_message(4, 1'b1);
    endtask

    task automatic test_random_keys();
        for (int p = 0; p < 7; p++) begin
            case (p)
                0:       write_cipher_key(32'hFFFF_FFFF);
                1:       write_cipher_key(32'h0000_0000);
                default: write_cipher_key($urandom());
            endcase
            random_words(130);
        end
    endtask

    task automatic test_back_to_back();
        write_cipher_key($urandom());
        gapless = 1'b1;
        random_words(150);
        gapless = 1'b0;
    endtask

    // ---------------- result checking and watchdog ----------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_out.size() == 0) begin
                $error("unexpected result: result_word %h last_out %b",
                       o_m_axis_tdata, o_m_axis_tlast);
                error_count++;
            end else begin
                t_cipher_out exp_item;
                exp_item = expected_out.pop_front();
                if (o_m_axis_tdata !== exp_item.word) begin
                    $error("result_word: expected %h, got %h", exp_item.word, o_m_axis_tdata);
                    error_count++;
                end
                if (o_m_axis_tlast !== exp_item.last) begin
                    $error("last_out: expected %b, got %b", exp_item.last, o_m_axis_tlast);
                    error_count++;
                end
            end
        end

        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver stalls at random
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
            rx_hold = pick_gap();
        end
    end

    initial begin
        error_count     = 0;
        idle_cycles     = 0;
        rx_hold         = 0;
        gapless         = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = OP_ENCRYPT;
        i_s_axis_tlast  = 1'b0;
        i_m_axis_tready = 1'b0;
        expand_key('0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_schedule();
        test_key_extremes();
        test_round_trip();
        test_random_keys();
        test_back_to_back();

        wait_drain();
        repeat (ROUNDS + 16) @(posedge i_clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
